@@ rtl/assert_macros.svh @@
// Assertion macros used by the deframer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WSD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define WSD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/wsd_pkg.sv @@
// Types and constants for the WebSocket frame deframer.
package wsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 3;
    localparam int KPOS_W   = 2;

    localparam int FLAG_BIT = 7;

    localparam logic [6:0]       LEN7_EXT16 = 7'd126;
    localparam logic [6:0]       LEN7_EXT64 = 7'd127;
    localparam logic [CNT_W-1:0] EXT16_LAST = 3'd1;
    localparam logic [CNT_W-1:0] EXT64_LAST = 3'd7;
    localparam logic [CNT_W-1:0] KEY_LAST   = 3'd3;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } wsd_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                final_fragment;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                last_of_frame;
        logic                empty_frame;
    } wsd_result_t;

endpackage

@@ rtl/wsd_channels.sv @@
// Handshake channels for received stream bytes and deframed results.
interface wsd_rx_if import wsd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if import wsd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   payload_byte;
    logic                final_fragment;
    logic [OPCODE_W-1:0] frame_opcode;
    logic                last_of_frame;
    logic                empty_frame;

    modport source (
        output valid, output payload_byte, output final_fragment,
        output frame_opcode, output last_of_frame, output empty_frame,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input final_fragment,
        input frame_opcode, input last_of_frame, input empty_frame,
        output ready
    );
endinterface

@@ rtl/wsd_in_stage.sv @@
// Input register holding one received stream byte.
module wsd_in_stage import wsd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    wsd_rx_if.sink            rx,
    input  logic              take,
    output logic              byte_valid,
    output logic [BYTE_W-1:0] byte_data
);

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] data_reg;

    assign rx.ready   = !vld_reg || take;
    assign byte_valid = vld_reg;
    assign byte_data  = data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (rx.valid && rx.ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            data_reg <= rx.rx_byte;
        end
    end

endmodule

@@ rtl/wsd_core.sv @@
// Frame header parser and payload unmasking.
`include "assert_macros.svh"

module wsd_core import wsd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] byte_data,
    input  logic              res_free,
    output logic              take,
    output logic              res_load,
    output wsd_result_t       res_next
);

    wsd_phase_t          phase_reg, phase_next;
    logic                fin_reg, fin_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic                masked_reg, masked_next;
    logic [LEN_W-1:0]    rem_len_reg, rem_len_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KPOS_W-1:0]   kpos_reg, kpos_next;

    logic [6:0]          len7;
    logic [LEN_W-1:0]    ext_len;
    logic [LEN_W-1:0]    rem_dec;
    logic [LEN_W-1:0]    len_val;
    logic [BYTE_W-1:0]   key_byte;
    logic                len_done;
    logic                hdr_done;
    logic                emit;

    assign take     = byte_valid && res_free;
    assign res_load = take && emit;

    always_comb
    begin
        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        rem_len_next = rem_len_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        kpos_next    = kpos_reg;
        emit         = 1'b0;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        len7         = byte_data[6:0];
        ext_len      = {rem_len_reg[LEN_W-BYTE_W-1:0], byte_data};
        rem_dec      = rem_len_reg - LEN_W'(1);
        len_val      = rem_len_reg;

        res_next.payload_byte   = '0;
        res_next.final_fragment = fin_reg;
        res_next.frame_opcode   = opcode_reg;
        res_next.last_of_frame  = 1'b1;
        res_next.empty_frame    = 1'b1;

        case (phase_reg)
            PH_HDR1:
            begin
                masked_next = byte_data[FLAG_BIT];
                cnt_next    = '0;
                if (len7 == LEN7_EXT16)
                begin
                    rem_len_next = '0;
                    phase_next   = PH_EXT16;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    rem_len_next = '0;
                    phase_next   = PH_EXT64;
                end
                else
                begin
                    rem_len_next = LEN_W'(len7);
                    len_val      = LEN_W'(len7);
                    len_done     = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                rem_len_next = ext_len;
                if (cnt_reg == ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                begin
                    len_val  = ext_len;
                    len_done = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[KEY_W-BYTE_W-1:0], byte_data};
                if (cnt_reg >= KEY_LAST)
                begin
                    hdr_done = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            PH_DATA:
            begin
                emit                   = 1'b1;
                res_next.payload_byte  = byte_data ^ (masked_reg ? key_byte : '0);
                res_next.last_of_frame = (rem_dec == '0);
                res_next.empty_frame   = 1'b0;
                rem_len_next           = rem_dec;
                kpos_next              = kpos_reg + KPOS_W'(1);
                if (rem_dec == '0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                fin_next    = byte_data[FLAG_BIT];
                opcode_next = byte_data[OPCODE_W-1:0];
                phase_next  = PH_HDR1;
            end
        endcase

        if (len_done)
        begin
            cnt_next = '0;
            key_next = '0;
            if (masked_next)
            begin
                phase_next = PH_KEY;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            cnt_next  = '0;
            kpos_next = '0;
            if (len_val == '0)
            begin
                emit       = 1'b1;
                phase_next = PH_HDR0;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            opcode_reg  <= '0;
            masked_reg  <= 1'b0;
            rem_len_reg <= '0;
            cnt_reg     <= '0;
            key_reg     <= '0;
            kpos_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            rem_len_reg <= rem_len_next;
            cnt_reg     <= cnt_next;
            key_reg     <= key_next;
            kpos_reg    <= kpos_next;
        end
    end

    `WSD_ASSERT(a_data_len_nonzero, phase_reg == PH_DATA |-> rem_len_reg != '0, "payload phase with zero length")
    `WSD_ASSERT(a_key_needs_mask, phase_reg == PH_KEY |-> masked_reg, "key phase on unmasked frame")
    `WSD_ASSERT(a_ext16_count, phase_reg == PH_EXT16 |-> cnt_reg <= EXT16_LAST, "16-bit length overran")
    `WSD_ASSERT_NEXT(a_ext64_entry, take && phase_reg == PH_HDR1 && byte_data[6:0] == LEN7_EXT64, phase_reg == PH_EXT64 && rem_len_reg == '0 && cnt_reg == '0, "64-bit length entry wrong")

endmodule

@@ rtl/wsd_out_stage.sv @@
// Result register driving the deframed output channel.
module wsd_out_stage import wsd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  wsd_result_t din,
    output logic        res_free,
    wsd_res_if.source   res
);

    logic        vld_reg;
    logic        vld_next;
    wsd_result_t data_reg;

    assign res_free           = !vld_reg || res.ready;
    assign res.valid          = vld_reg;
    assign res.payload_byte   = data_reg.payload_byte;
    assign res.final_fragment = data_reg.final_fragment;
    assign res.frame_opcode   = data_reg.frame_opcode;
    assign res.last_of_frame  = data_reg.last_of_frame;
    assign res.empty_frame    = data_reg.empty_frame;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket frame deframer top level.
// Takes one received stream byte per clock and sustains one byte per cycle with
// no gaps while res.ready stays high, through header, extended length, masking key
// and payload alike; a byte is held in the input register and, once the output
// register is free, its result is loaded into the output register that drives res.
// Header, length and key bytes give no result, except the byte that completes the
// header of a zero-length frame, which gives one marker word with empty_frame and
// last_of_frame set. Each payload byte comes out unmasked with the frame's FIN bit
// and opcode, and last_of_frame on the final byte. The rate is set by the parser
// step, whose longest path is the 64-bit length decrement and zero test; rx.ready
// follows res.ready combinationally when both registers are full.
module websocket_frame_deframer import wsd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    wsd_rx_if.sink    rx,
    wsd_res_if.source res
);

    logic              take;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              res_free;
    logic              res_load;
    wsd_result_t       res_next;

    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    wsd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_free   (res_free),
        .take       (take),
        .res_load   (res_load),
        .res_next   (res_next)
    );

    wsd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .din      (res_next),
        .res_free (res_free),
        .res      (res)
    );

endmodule
